@@ rtl/cfc_pkg.sv @@
// cfc_pkg: shared types and constants for the command frame checker.
// Holds the frame marks, verdict codes, result kinds and the queue entry type.
// No dependencies.
`default_nettype none

package cfc_pkg;

	localparam logic [7:0] HEAD_MARK = 8'hFB;
	localparam logic [7:0] TAIL_MARK = 8'hFE;
	localparam logic [7:0] MIN_FRAME = 8'd7;
	localparam logic [7:0] POS_MAX   = 8'd255;

	// Verdict codes carried by an end-of-frame word
	typedef enum logic [2:0] {
		VERDICT_OK        = 3'd0,
		VERDICT_SHORT     = 3'd1,
		VERDICT_BAD_HEAD  = 3'd2,
		VERDICT_BAD_TAIL  = 3'd3,
		VERDICT_BAD_SUM   = 3'd4,
		VERDICT_TOO_LONG  = 3'd5
	} verdict_t;

	// Result word kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// One queue entry: all results caused by one received byte
	typedef struct packed {
		logic       has_pay;
		logic [7:0] data;
		logic       has_vrd;
		verdict_t   verdict;
		logic [7:0] command;
		logic [7:0] length;
	} cfc_entry_t;

endpackage

`default_nettype wire

@@ rtl/cfc_front.sv @@
// cfc_front: takes received bytes, tracks frame state and classifies each byte.
// Emits one queue entry per byte that yields a payload word and/or a verdict.
// Depends on cfc_pkg.
`default_nettype none

module cfc_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire [7:0]        rx_byte,
	input  wire              frame_end,
	output logic             ent_push,
	output cfc_pkg::cfc_entry_t ent
);
	import cfc_pkg::*;

	logic [7:0] pos_q;
	logic       too_long_q;
	logic [7:0] sum_q;
	logic [7:0] prev0_q;
	logic [7:0] prev1_q;
	logic       head_good_q;
	logic [7:0] cmd_q;
	logic [7:0] len_q;

	logic       too_long;
	logic       head_good;
	logic [7:0] cmd_next;
	logic [7:0] len_next;
	logic [7:0] sum_next;
	logic       pay;
	verdict_t   vrd;

	// Classify the byte against the current frame state
	always_comb begin
		too_long  = too_long_q || (pos_q == POS_MAX);
		head_good = head_good_q && !((pos_q < 8'd2) && (rx_byte != HEAD_MARK));
		cmd_next  = (pos_q == 8'd2) ? rx_byte : cmd_q;
		len_next  = (pos_q == 8'd3) ? rx_byte : len_q;
		sum_next  = (pos_q >= 8'd2) ? sum_q + prev1_q : sum_q;
		pay       = !too_long && (pos_q >= 8'd4) &&
			({1'b0, pos_q} < (9'd4 + {1'b0, len_q}));
		if (too_long) begin
			vrd = VERDICT_TOO_LONG;
		end else if (pos_q < MIN_FRAME - 8'd1) begin
			vrd = VERDICT_SHORT;
		end else if (!head_good) begin
			vrd = VERDICT_BAD_HEAD;
		end else if ((rx_byte != TAIL_MARK) || (prev0_q != TAIL_MARK)) begin
			vrd = VERDICT_BAD_TAIL;
		end else if (sum_q != prev1_q) begin
			vrd = VERDICT_BAD_SUM;
		end else begin
			vrd = VERDICT_OK;
		end
	end

	// Build the entry for the queue
	always_comb begin
		ent_push    = in_valid && (pay || frame_end);
		ent.has_pay = pay;
		ent.data    = rx_byte;
		ent.has_vrd = frame_end;
		ent.verdict = vrd;
		ent.command = cmd_next;
		ent.length  = len_next;
	end

	// Advance frame state; clear it after the last byte of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			too_long_q  <= 1'b0;
			sum_q       <= '0;
			prev0_q     <= '0;
			prev1_q     <= '0;
			head_good_q <= 1'b1;
			cmd_q       <= '0;
			len_q       <= '0;
		end else if (in_valid) begin
			if (frame_end) begin
				pos_q       <= '0;
				too_long_q  <= 1'b0;
				sum_q       <= '0;
				prev0_q     <= '0;
				prev1_q     <= '0;
				head_good_q <= 1'b1;
				cmd_q       <= '0;
				len_q       <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 8'd1;
				end
				too_long_q  <= too_long;
				sum_q       <= sum_next;
				prev0_q     <= rx_byte;
				prev1_q     <= prev0_q;
				head_good_q <= head_good;
				cmd_q       <= cmd_next;
				len_q       <= len_next;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/cfc_queue.sv @@
// cfc_queue: short first-in first-out queue of classified entries.
// Decouples the byte front end from the result back end.
// Depends on cfc_pkg.
`default_nettype none

module cfc_queue #(
	parameter int DEPTH = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire cfc_pkg::cfc_entry_t wr_ent,
	input  wire                 rd_en,
	output cfc_pkg::cfc_entry_t rd_ent,
	output logic                q_full,
	output logic                q_empty
);
	import cfc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cfc_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (count_q == FULL_CNT);
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_ent  = mem_q[rd_ptr_q];

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_ent;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/cfc_back.sv @@
// cfc_back: splits each queue entry into result words and hands them out.
// A payload word goes first, then the verdict word of the same byte.
// Depends on cfc_pkg.
`default_nettype none

module cfc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire cfc_pkg::cfc_entry_t head,
	input  wire                 head_valid,
	output logic                head_done,
	input  wire                 pop,
	output logic                item_kind,
	output logic [7:0]          data_byte,
	output logic [2:0]          verdict,
	output logic [7:0]          command,
	output logic [7:0]          payload_len,
	output logic                last
);
	import cfc_pkg::*;

	logic pay_sent_q;
	logic show_pay;
	logic take;

	// Select the word to present from the head entry
	always_comb begin
		show_pay    = head.has_pay && !pay_sent_q;
		item_kind   = show_pay ? KIND_PAYLOAD : KIND_VERDICT;
		data_byte   = show_pay ? head.data : 8'd0;
		verdict     = show_pay ? VERDICT_OK : head.verdict;
		command     = head.command;
		payload_len = head.length;
		last        = show_pay ? !head.has_vrd : 1'b1;
		take        = pop && head_valid;
		head_done   = take && last;
	end

	// Remember that the payload word of a two-word entry has gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_sent_q <= 1'b0;
		end else if (take) begin
			pay_sent_q <= !last;
		end
	end

endmodule

`default_nettype wire

@@ rtl/command_frame_checker_core.sv @@
// command_frame_checker_core: frame checker for received command buffers.
// Instantiates cfc_front, cfc_queue and cfc_back; depends on cfc_pkg.
//
// Usage:
//   Input channel: drive rx_byte and frame_end and raise push; a byte is
//   taken at a rising edge with push high and full low. frame_end marks the
//   last byte of a buffer (layout FB FB, command, length, payload, sum, FE FE).
//   Result channel: while empty is low the oldest result word is on
//   item_kind, data_byte, verdict, command, payload_len and last; it is taken
//   at a rising edge with pop high. Payload bytes come out as kind 0 words,
//   and each buffer ends with one kind 1 word carrying the verdict.
//   A result word is registered in the entry queue when its byte is taken.
//   Throughput: one byte per cycle while full is low; a byte that yields both
//   a payload word and a verdict gives two words; the result side sets the pace.
//   The entry queue holds QUEUE_DEPTH bytes' worth of results; when the
//   receiver stalls it fills and full rises, holding off further bytes.
//   Reset (arst_n low) empties the queue and clears the frame state.
`default_nettype none

module command_frame_checker_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire [7:0]  rx_byte,
	input  wire        frame_end,
	output logic       empty,
	input  wire        pop,
	output logic       item_kind,
	output logic [7:0] data_byte,
	output logic [2:0] verdict,
	output logic [7:0] command,
	output logic [7:0] payload_len,
	output logic       last
);
	import cfc_pkg::*;

	cfc_entry_t fe_ent;
	cfc_entry_t hd_ent;
	logic       fe_push;
	logic       accept;
	logic       hd_done;

	assign accept = push && !full;

	cfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.ent_push  (fe_push),
		.ent       (fe_ent)
	);

	cfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_push),
		.wr_ent  (fe_ent),
		.rd_en   (hd_done),
		.rd_ent  (hd_ent),
		.q_full  (full),
		.q_empty (empty)
	);

	cfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (hd_ent),
		.head_valid  (!empty),
		.head_done   (hd_done),
		.pop         (pop),
		.item_kind   (item_kind),
		.data_byte   (data_byte),
		.verdict     (verdict),
		.command     (command),
		.payload_len (payload_len),
		.last        (last)
	);

	// A verdict word always closes the results of its byte
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (item_kind == KIND_VERDICT)) |-> last)
		else $error("verdict word without last");

	// Payload words carry no verdict code
	a_payload_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (item_kind == KIND_PAYLOAD)) |-> (verdict == VERDICT_OK))
		else $error("payload word with verdict code");

	// After the first word of a two-word entry its verdict word follows
	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=> (!empty && (item_kind == KIND_VERDICT)))
		else $error("verdict word lost after payload word");

	// The queue cannot be full and empty at once
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("queue full and empty together");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for command_frame_checker_core.
// Runs directed and random receive buffers through the core and checks every
// result word against a frame predictor kept here; depends on cfc_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cfc_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_BYTES = 850;

	// One expected result word
	typedef struct {
		logic       kind;
		logic [7:0] data;
		verdict_t   vrd;
		logic [7:0] cmd;
		logic [7:0] len;
		logic       is_last;
	} frame_word_t;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_RHYTHM
	} rx_mode_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] rx_byte;
	logic       frame_end;
	logic       empty;
	logic       pop;
	logic       item_kind;
	logic [7:0] data_byte;
	logic [2:0] verdict;
	logic [7:0] command;
	logic [7:0] payload_len;
	logic       last;

	// Frame predictor state
	logic [7:0] fr_pos;
	bit         fr_overflow;
	logic [7:0] fr_sum;
	logic [7:0] fr_prev;
	logic [7:0] fr_prev2;
	bit         fr_head_ok;
	logic [7:0] fr_cmd;
	logic [7:0] fr_len;

	frame_word_t expected_words[$];
	logic [7:0]  frame_buf[$];

	int mismatches  = 0;
	int bytes_sent  = 0;
	int burst_left  = 0;
	bit steady_send = 0;
	int hold_asked  = 0;
	int cycle_count = 0;

	command_frame_checker_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.frame_end   (frame_end),
		.empty       (empty),
		.pop         (pop),
		.item_kind   (item_kind),
		.data_byte   (data_byte),
		.verdict     (verdict),
		.command     (command),
		.payload_len (payload_len),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort a run that has stalled
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	task automatic clear_frame();
		fr_pos      = '0;
		fr_overflow = 1'b0;
		fr_sum      = '0;
		fr_prev     = '0;
		fr_prev2    = '0;
		fr_head_ok  = 1'b1;
		fr_cmd      = '0;
		fr_len      = '0;
	endtask

	task automatic add_word(input logic kind, input logic [7:0] data, input verdict_t vrd,
			input logic is_last);
		frame_word_t w;
		w.kind    = kind;
		w.data    = data;
		w.vrd     = vrd;
		w.cmd     = fr_cmd;
		w.len     = fr_len;
		w.is_last = is_last;
		expected_words.push_back(w);
	endtask

	// Advance the frame state by one received byte and queue the words it yields
	task automatic predict_byte(input logic [7:0] b, input logic e);
		bit          over;
		logic [7:0]  sum_old;
		int unsigned p;
		verdict_t    v;
		p    = fr_pos;
		over = fr_overflow || (fr_pos == POS_MAX);
		if (over)
			fr_overflow = 1'b1;
		if (p < 2 && b != HEAD_MARK)
			fr_head_ok = 1'b0;
		if (p == 2)
			fr_cmd = b;
		if (p == 3)
			fr_len = b;
		// running sum lags two bytes behind, so the checksum byte never enters it
		sum_old = fr_sum;
		if (p >= 2)
			fr_sum = fr_sum + fr_prev2;
		if (!over && p >= 4 && p < 4 + int'(fr_len))
			add_word(KIND_PAYLOAD, b, VERDICT_OK, !e);
		if (e) begin
			if (over)
				v = VERDICT_TOO_LONG;
			else if (p + 1 < int'(MIN_FRAME))
				v = VERDICT_SHORT;
			else if (!fr_head_ok)
				v = VERDICT_BAD_HEAD;
			else if (b != TAIL_MARK || fr_prev != TAIL_MARK)
				v = VERDICT_BAD_TAIL;
			else if (sum_old != fr_prev2)
				v = VERDICT_BAD_SUM;
			else
				v = VERDICT_OK;
			add_word(KIND_VERDICT, 8'h00, v, 1'b1);
			clear_frame();
		end else begin
			fr_prev2 = fr_prev;
			fr_prev  = b;
			if (fr_pos != POS_MAX)
				fr_pos = fr_pos + 8'd1;
		end
	endtask

	// ---------------------------------------------------------------- result check

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		frame_word_t want;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, expected none, actual kind %0h data %0h",
					$time, item_kind, data_byte);
			end else begin
				want = expected_words.pop_front();
				check_field("item_kind", want.kind, item_kind);
				check_field("data_byte", want.data, data_byte);
				check_field("verdict", want.vrd, verdict);
				check_field("command", want.cmd, command);
				check_field("payload_len", want.len, payload_len);
				check_field("last", want.is_last, last);
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// Stall on a changing pattern; honour long hold-off requests
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       hold_done;
		int       tick;
		pop       = 1'b0;
		mode      = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		hold_done = 0;
		tick      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if (hold_left == 0 && hold_done != hold_asked) begin
				hold_done = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				case (mode)
					RX_FREE:   pop = 1'b1;
					RX_COIN:   pop = 1'($urandom_range(0, 1));
					RX_SPARSE: pop = ($urandom_range(0, 3) == 0);
					default:   pop = (tick % 5) != 0;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// Offer one byte and hold it until taken; called just after a falling edge
	task automatic send_byte(input logic [7:0] b, input logic e);
		int gap;
		if (!steady_send && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		push      = 1'b1;
		rx_byte   = b;
		frame_end = e;
		do @(posedge clk); while (full);
		predict_byte(b, e);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_buffer();
		foreach (frame_buf[i])
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// Rewrite the checksum byte from the bytes ahead of it
	task automatic fix_checksum();
		logic [7:0] s;
		s = '0;
		for (int i = 0; i < frame_buf.size() - 3; i++)
			s = s + frame_buf[i];
		frame_buf[frame_buf.size() - 3] = s;
	endtask

	// Build a well-formed frame with random payload
	task automatic build_frame(input logic [7:0] cmd, input int len);
		frame_buf.delete();
		frame_buf.push_back(HEAD_MARK);
		frame_buf.push_back(HEAD_MARK);
		frame_buf.push_back(cmd);
		frame_buf.push_back(len[7:0]);
		for (int i = 0; i < len; i++)
			frame_buf.push_back(8'($urandom_range(0, 255)));
		frame_buf.push_back(8'h00);
		frame_buf.push_back(TAIL_MARK);
		frame_buf.push_back(TAIL_MARK);
		fix_checksum();
	endtask

	task automatic fill_noise(input int len);
		frame_buf.delete();
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 3))
				0:       frame_buf.push_back(HEAD_MARK);
				1:       frame_buf.push_back(TAIL_MARK);
				default: frame_buf.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// Damage a frame in one of several ways
	task automatic corrupt_frame();
		int idx;
		int keep;
		idx = $urandom_range(0, frame_buf.size() - 1);
		case ($urandom_range(0, 5))
			0: frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
			1: begin
				keep = $urandom_range(1, frame_buf.size() - 1);
				while (frame_buf.size() > keep)
					void'(frame_buf.pop_back());
			end
			2: frame_buf.push_back(8'($urandom_range(0, 255)));
			3: begin
				// misdeclared length with a consistent sum
				frame_buf[3] = 8'($urandom_range(0, 255));
				fix_checksum();
			end
			4: frame_buf[frame_buf.size() - 3] += 8'($urandom_range(1, 255));
			default: begin
				idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
					: frame_buf.size() - 1 - $urandom_range(0, 1);
				frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
			end
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_good_frames();
		logic [7:0] vals[5];
		vals = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80};
		build_frame(8'h00, 0);
		send_buffer();
		build_frame(8'hFF, 5);
		foreach (vals[i])
			frame_buf[4 + i] = vals[i];
		fix_checksum();
		send_buffer();
	endtask

	task automatic test_short_buffers();
		frame_buf = '{HEAD_MARK};
		send_buffer();
		frame_buf = '{TAIL_MARK, TAIL_MARK};
		send_buffer();
		// six bytes: a minimal frame missing its final tail mark
		build_frame(8'h11, 0);
		void'(frame_buf.pop_back());
		send_buffer();
	endtask

	task automatic test_bad_header();
		build_frame(8'h22, 1);
		frame_buf[0] = 8'h00;
		send_buffer();
		build_frame(8'h23, 1);
		frame_buf[1] = 8'hFA;
		send_buffer();
	endtask

	task automatic test_bad_tail();
		build_frame(8'h33, 2);
		frame_buf[frame_buf.size() - 1] = 8'hFF;
		send_buffer();
		build_frame(8'h34, 2);
		frame_buf[frame_buf.size() - 2] = 8'h7E;
		send_buffer();
	endtask

	task automatic test_bad_checksum();
		build_frame(8'h44, 3);
		frame_buf[frame_buf.size() - 3] += 8'd1;
		send_buffer();
	endtask

	// Length byte points past the checksum: sum and tail leave as payload
	task automatic test_length_overrun();
		build_frame(8'h55, 2);
		frame_buf[3] = 8'd10;
		fix_checksum();
		send_buffer();
		build_frame(8'h56, 0);
		frame_buf[3] = 8'hFF;
		fix_checksum();
		send_buffer();
	endtask

	task automatic test_long_buffers();
		// longest frame that still fits
		build_frame(8'h66, 248);
		send_buffer();
		// one byte more trips the too-long flag
		build_frame(8'h67, 249);
		send_buffer();
		fill_noise(300);
		send_buffer();
	endtask

	// Stall the receiver while bytes keep coming, so the core fills up
	task automatic test_backpressure();
		steady_send = 1'b1;
		hold_asked++;
		build_frame(8'h77, 60);
		send_buffer();
		steady_send = 1'b0;
	endtask

	task automatic test_random();
		int goal;
		int pick;
		int len;
		goal = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				fill_noise($urandom_range(1, 12));
			end else begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 248)
					: $urandom_range(0, 24);
				build_frame(8'($urandom_range(0, 255)), len);
				if (pick >= 70)
					corrupt_frame();
			end
			send_buffer();
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		rx_byte   = '0;
		frame_end = 1'b0;
		clear_frame();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_good_frames();
		test_short_buffers();
		test_bad_header();
		test_bad_tail();
		test_bad_checksum();
		test_length_overrun();
		test_long_buffers();
		test_backpressure();
		test_random();

		// drain what is still owed, then allow for stray words
		push = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ command_frame_checker_core.f @@
rtl/cfc_pkg.sv
rtl/cfc_front.sv
rtl/cfc_queue.sv
rtl/cfc_back.sv
rtl/command_frame_checker_core.sv
bench/tb_top.sv
